// File: hdl/rrb_pkg.sv
// package: widths, request codes, rotation codes, register indexes and payload types of the blit address generator
`timescale 1ns / 1ps

package rrb_pkg;

    localparam int ADDR_BITS  = 24;
    localparam int COORD_BITS = 12;
    localparam int PIXEL_BITS = 32;
    localparam int SIZE_BITS  = COORD_BITS + 1;
    localparam int ROT_BITS   = 2;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = SIZE_BITS;

    typedef logic [1:0] t_req_type;
    localparam t_req_type REQ_BEGIN  = 2'd0;
    localparam t_req_type REQ_WRITE  = 2'd1;
    localparam t_req_type REQ_READ   = 2'd2;
    localparam t_req_type REQ_UNUSED = 2'd3;

    typedef logic [ROT_BITS-1:0] t_rot;
    localparam t_rot ROT_0   = 2'd0;
    localparam t_rot ROT_90  = 2'd1;
    localparam t_rot ROT_180 = 2'd2;
    localparam t_rot ROT_270 = 2'd3;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ROTATION      = 3'd0;
    localparam t_cfg_idx CFG_ROW_PITCH     = 3'd1;
    localparam t_cfg_idx CFG_ORIGIN_X      = 3'd2;
    localparam t_cfg_idx CFG_ORIGIN_Y      = 3'd3;
    localparam t_cfg_idx CFG_ACTIVE_WIDTH  = 3'd4;
    localparam t_cfg_idx CFG_ACTIVE_HEIGHT = 3'd5;

    typedef struct packed {
        t_req_type             req_type;
        logic [COORD_BITS-1:0] rect_left;
        logic [COORD_BITS-1:0] rect_top;
        logic [SIZE_BITS-1:0]  rect_width;
        logic [SIZE_BITS-1:0]  rect_height;
        logic [PIXEL_BITS-1:0] pixel_in;
    } t_req;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  pixel_address;
        logic                  write_enable;
        logic [PIXEL_BITS-1:0] pixel_out;
        logic                  last_pixel;
        logic                  overrun;
    } t_res;

endpackage

// File: hdl/rrb_req_if.sv
// interface: request channel carrying one input transaction
`timescale 1ns / 1ps

interface rrb_req_if import rrb_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/rrb_res_if.sv
// interface: result channel carrying one address transaction
`timescale 1ns / 1ps

interface rrb_res_if import rrb_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/rotated_rect_blit_address_gen_core.sv
// top level: rotated rectangle blit address generator
// a request is registered in stage 1, then in stage 2, then in the result register
// throughput: one transaction per cycle unless stalled, set by the single add-step per pixel
// begin transactions produce no result; stalls on the result side back up two stages
// reset (synchronous, active low) restores register defaults and clears the rectangle state
`timescale 1ns / 1ps

module rotated_rect_blit_address_gen_core import rrb_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  t_cfg_idx                 i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    rrb_req_if.sink                  i_req,
    rrb_res_if.source                o_res
);

    // configuration registers
    t_rot                  r_rotation;
    logic [SIZE_BITS-1:0]  r_row_pitch;
    logic [COORD_BITS-1:0] r_origin_x;
    logic [COORD_BITS-1:0] r_origin_y;
    logic [SIZE_BITS-1:0]  r_active_width;
    logic [SIZE_BITS-1:0]  r_active_height;

    // rectangle state
    logic [SIZE_BITS-1:0]  r_held_width;
    logic [SIZE_BITS-1:0]  r_held_height;
    logic [SIZE_BITS-1:0]  r_column_count;
    logic [SIZE_BITS-1:0]  r_row_count;
    logic [ADDR_BITS-1:0]  r_line_address;
    logic [ADDR_BITS-1:0]  r_current_address;
    logic                  r_rect_active;

    logic [SIZE_BITS-1:0]  n_column_count;
    logic [SIZE_BITS-1:0]  n_row_count;
    logic [ADDR_BITS-1:0]  n_line_address;
    logic [ADDR_BITS-1:0]  n_current_address;
    logic                  n_rect_active;

    // pipeline
    logic                  r_s1_valid;
    t_req                  r_s1;
    logic                  r_s2_valid;
    t_req_type             r_s2_req;
    logic [ADDR_BITS-1:0]  r_s2_fac;
    logic [ADDR_BITS-1:0]  r_s2_xoff;
    logic [SIZE_BITS-1:0]  r_s2_width;
    logic [SIZE_BITS-1:0]  r_s2_height;
    logic [PIXEL_BITS-1:0] r_s2_pixel;
    logic                  r_out_valid;
    t_res                  r_out;

    logic [ADDR_BITS-1:0]  n_s2_fac;
    logic [ADDR_BITS-1:0]  n_s2_xoff;
    t_res                  n_res;

    logic                  s2_has_res;
    logic                  out_free;
    logic                  s2_go;
    logic                  s2_free;
    logic                  s1_free;
    logic                  accept;

    logic [ADDR_BITS-1:0]  x0;
    logic [ADDR_BITS-1:0]  x1;
    logic [ADDR_BITS-1:0]  y0;
    logic [ADDR_BITS-1:0]  y1;
    logic [ADDR_BITS-1:0]  left_a;
    logic [ADDR_BITS-1:0]  top_a;
    logic [ADDR_BITS-1:0]  pitch_a;
    logic [ADDR_BITS-1:0]  col_step;
    logic [ADDR_BITS-1:0]  row_step;
    logic [ADDR_BITS+SIZE_BITS-1:0] start_prod;
    logic [ADDR_BITS-1:0]  start_address;
    logic [SIZE_BITS-1:0]  col_inc;
    logic [SIZE_BITS-1:0]  row_inc;

    // handshake
    assign s2_has_res  = (r_s2_req == REQ_WRITE) || (r_s2_req == REQ_READ);
    assign out_free    = !r_out_valid || o_res.ready;
    assign s2_go       = r_s2_valid && (!s2_has_res || out_free);
    assign s2_free     = !r_s2_valid || s2_go;
    assign s1_free     = !r_s1_valid || s2_free;
    assign accept      = i_req.valid && s1_free;
    assign i_req.ready = s1_free;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation      <= ROT_0;
            r_row_pitch     <= SIZE_BITS'(1);
            r_origin_x      <= '0;
            r_origin_y      <= '0;
            r_active_width  <= SIZE_BITS'(1);
            r_active_height <= SIZE_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROTATION:      r_rotation      <= i_cfg_data[ROT_BITS-1:0];
                CFG_ROW_PITCH:     r_row_pitch     <= i_cfg_data[SIZE_BITS-1:0];
                CFG_ORIGIN_X:      r_origin_x      <= i_cfg_data[COORD_BITS-1:0];
                CFG_ORIGIN_Y:      r_origin_y      <= i_cfg_data[COORD_BITS-1:0];
                CFG_ACTIVE_WIDTH:  r_active_width  <= i_cfg_data[SIZE_BITS-1:0];
                CFG_ACTIVE_HEIGHT: r_active_height <= i_cfg_data[SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: window corner terms folded with the rectangle corner
    always_comb begin
        x0      = ADDR_BITS'(r_origin_x);
        y0      = ADDR_BITS'(r_origin_y);
        x1      = x0 + ADDR_BITS'(r_active_width) - ADDR_BITS'(1);
        y1      = y0 + ADDR_BITS'(r_active_height) - ADDR_BITS'(1);
        left_a  = ADDR_BITS'(r_s1.rect_left);
        top_a   = ADDR_BITS'(r_s1.rect_top);
        case (r_rotation)
            ROT_0: begin
                n_s2_fac  = y0 + top_a;
                n_s2_xoff = x0 + left_a;
            end
            ROT_90: begin
                n_s2_fac  = y0 + left_a;
                n_s2_xoff = x1 - top_a;
            end
            ROT_180: begin
                n_s2_fac  = y1 - top_a;
                n_s2_xoff = x1 - left_a;
            end
            default: begin
                n_s2_fac  = y1 - left_a;
                n_s2_xoff = x0 + top_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= i_req.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_valid) begin
            r_s2_req    <= r_s1.req_type;
            r_s2_fac    <= n_s2_fac;
            r_s2_xoff   <= n_s2_xoff;
            r_s2_width  <= r_s1.rect_width;
            r_s2_height <= r_s1.rect_height;
            r_s2_pixel  <= r_s1.pixel_in;
        end
    end

    // stage 2: start address on begin, address stepping on pixels
    always_comb begin
        pitch_a       = ADDR_BITS'(r_row_pitch);
        start_prod    = r_s2_fac * r_row_pitch;
        start_address = start_prod[ADDR_BITS-1:0] + r_s2_xoff;
        case (r_rotation)
            ROT_0: begin
                col_step = ADDR_BITS'(1);
                row_step = pitch_a;
            end
            ROT_90: begin
                col_step = pitch_a;
                row_step = '1;
            end
            ROT_180: begin
                col_step = '1;
                row_step = -pitch_a;
            end
            default: begin
                col_step = -pitch_a;
                row_step = ADDR_BITS'(1);
            end
        endcase

        col_inc           = r_column_count + SIZE_BITS'(1);
        row_inc           = r_row_count + SIZE_BITS'(1);
        n_column_count    = r_column_count;
        n_row_count       = r_row_count;
        n_line_address    = r_line_address;
        n_current_address = r_current_address;
        n_rect_active     = r_rect_active;

        n_res.pixel_address = '0;
        n_res.write_enable  = 1'b0;
        n_res.pixel_out     = '0;
        n_res.last_pixel    = 1'b0;
        n_res.overrun       = 1'b0;

        if (r_s2_req == REQ_BEGIN) begin
            n_column_count    = '0;
            n_row_count       = '0;
            n_line_address    = start_address;
            n_current_address = start_address;
            n_rect_active     = (r_s2_width != '0) && (r_s2_height != '0);
        end else if (s2_has_res) begin
            if (!r_rect_active) begin
                n_res.overrun = 1'b1;
            end else begin
                n_res.pixel_address = r_current_address;
                n_res.write_enable  = (r_s2_req == REQ_WRITE);
                n_res.pixel_out     = (r_s2_req == REQ_WRITE) ? r_s2_pixel : '0;
                if (col_inc >= r_held_width) begin
                    n_column_count    = '0;
                    n_row_count       = row_inc;
                    n_line_address    = r_line_address + row_step;
                    n_current_address = r_line_address + row_step;
                    if (row_inc >= r_held_height) begin
                        n_rect_active    = 1'b0;
                        n_res.last_pixel = 1'b1;
                    end
                end else begin
                    n_column_count    = col_inc;
                    n_current_address = r_current_address + col_step;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_width      <= '0;
            r_held_height     <= '0;
            r_column_count    <= '0;
            r_row_count       <= '0;
            r_line_address    <= '0;
            r_current_address <= '0;
            r_rect_active     <= 1'b0;
        end else if (s2_go) begin
            if (r_s2_req == REQ_BEGIN) begin
                r_held_width  <= r_s2_width;
                r_held_height <= r_s2_height;
            end
            r_column_count    <= n_column_count;
            r_row_count       <= n_row_count;
            r_line_address    <= n_line_address;
            r_current_address <= n_current_address;
            r_rect_active     <= n_rect_active;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_go && s2_has_res) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && s2_has_res) begin
            r_out <= n_res;
        end
    end

endmodule
